FILE: design/pitb_pkg.sv
package pitb_pkg;

    localparam int CW    = 16;
    localparam int DW    = CW + 1;
    localparam int PRW   = 2 * DW;
    localparam int CRW   = 2 * DW + 1;
    localparam int MW    = 2 * DW;
    localparam int HW    = DW;
    localparam int SQW   = 2 * MW;
    localparam int SW    = SQW + 2;
    localparam int FRACS = 20;
    localparam int RW    = SW + FRACS;
    localparam int LW    = RW / 2;
    localparam int QW    = 20;
    localparam int QF    = 16;
    localparam int RMW   = LW + QW;
    localparam int MWT   = 17;
    localparam int WWW   = QW + 1;
    localparam int XW    = QW + 2;

    localparam logic [MWT-1:0]        MIN_WEIGHT_RST = MWT'(1);
    localparam logic [XW-1:0]         ONE_Q          = XW'(1) << QF;
    localparam logic signed [XW-1:0]  W_FLOOR        = {2'b11, {QW{1'b0}}};
    localparam logic [WWW-1:0]        W_OUT_MIN      = {1'b1, {QW{1'b0}}};

    typedef logic signed [CW-1:0] t_coord;

endpackage

FILE: design/point_in_triangle_barycentric.sv
// Barycentric point-in-triangle test. One word (a point and three vertices, signed Q8.8)
// enters per clock and runs through the pipeline in order: six stages build the three
// cross products and their squared lengths, a 45-stage bit-per-stage square root yields
// the lengths, a 20-stage restoring divider forms the Q4.16 weights, and one output
// register holds the result. A stall on the output freezes the whole pipe, so throughput
// is one word per cycle while the output is taken. min_weight may be written only while
// the pipe is empty.
module point_in_triangle_barycentric (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pitb_pkg::t_coord           i_point_x,
    input  pitb_pkg::t_coord           i_point_y,
    input  pitb_pkg::t_coord           i_point_z,
    input  pitb_pkg::t_coord           i_vertex_a_x,
    input  pitb_pkg::t_coord           i_vertex_a_y,
    input  pitb_pkg::t_coord           i_vertex_a_z,
    input  pitb_pkg::t_coord           i_vertex_b_x,
    input  pitb_pkg::t_coord           i_vertex_b_y,
    input  pitb_pkg::t_coord           i_vertex_b_z,
    input  pitb_pkg::t_coord           i_vertex_c_x,
    input  pitb_pkg::t_coord           i_vertex_c_y,
    input  pitb_pkg::t_coord           i_vertex_c_z,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pitb_pkg::MWT-1:0]   i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [pitb_pkg::QW-1:0]    o_weight_u,
    output logic [pitb_pkg::QW-1:0]    o_weight_v,
    output logic [pitb_pkg::WWW-1:0]   o_weight_w,
    output logic                       o_inside_res,
    output logic                       o_degenerate
);
    import pitb_pkg::*;

    logic w_en;
    logic [MWT-1:0] r_min_weight;

    t_coord w_p1 [3][3];
    t_coord w_p2 [3][3];
    t_coord w_p3 [3][3];

    logic signed [DW-1:0]  r_e   [3][3];
    logic signed [DW-1:0]  r_f   [3][3];
    logic signed [PRW-1:0] r_m   [3][6];
    logic [MW-1:0]         r_mag [3][3];
    logic [2*HW-1:0]       r_hh  [3][3];
    logic [2*HW-1:0]       r_hl  [3][3];
    logic [2*HW-1:0]       r_ll  [3][3];
    logic [SQW-1:0]        r_sq  [3][3];
    logic [SW-1:0]         r_sum [3];
    logic                  r_v   [6];

    logic          w_sq_valid [3];
    logic [LW-1:0] w_len      [3];
    logic          w_u_valid;
    logic          w_v_valid;
    logic [QW-1:0] w_u;
    logic [QW-1:0] w_v;
    logic          r_dg [QW];

    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_weight <= MIN_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            r_min_weight <= i_cfg_data;
        end
    end

    assign w_p1[0] = '{i_vertex_a_x, i_vertex_a_y, i_vertex_a_z};
    assign w_p2[0] = '{i_vertex_b_x, i_vertex_b_y, i_vertex_b_z};
    assign w_p3[0] = '{i_vertex_c_x, i_vertex_c_y, i_vertex_c_z};
    assign w_p1[1] = '{i_point_x, i_point_y, i_point_z};
    assign w_p2[1] = '{i_vertex_b_x, i_vertex_b_y, i_vertex_b_z};
    assign w_p3[1] = '{i_vertex_c_x, i_vertex_c_y, i_vertex_c_z};
    assign w_p1[2] = '{i_point_x, i_point_y, i_point_z};
    assign w_p2[2] = '{i_vertex_a_x, i_vertex_a_y, i_vertex_a_z};
    assign w_p3[2] = '{i_vertex_c_x, i_vertex_c_y, i_vertex_c_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 6; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_v[0] <= i_in_valid;
            for (int s = 1; s < 6; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_tri
        logic signed [CRW-1:0] w_c   [3];
        logic signed [CRW-1:0] w_neg [3];

        for (genvar k = 0; k < 3; k++) begin : g_ax
            assign w_c[k]   = CRW'(r_m[g][2*k]) - CRW'(r_m[g][2*k+1]);
            assign w_neg[k] = -w_c[k];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_e[g][k] <= DW'(w_p1[g][k]) - DW'(w_p2[g][k]);
                    r_f[g][k] <= DW'(w_p2[g][k]) - DW'(w_p3[g][k]);
                end
                r_m[g][0] <= PRW'(r_e[g][1]) * PRW'(r_f[g][2]);
                r_m[g][1] <= PRW'(r_e[g][2]) * PRW'(r_f[g][1]);
                r_m[g][2] <= PRW'(r_e[g][2]) * PRW'(r_f[g][0]);
                r_m[g][3] <= PRW'(r_e[g][0]) * PRW'(r_f[g][2]);
                r_m[g][4] <= PRW'(r_e[g][0]) * PRW'(r_f[g][1]);
                r_m[g][5] <= PRW'(r_e[g][1]) * PRW'(r_f[g][0]);
                for (int k = 0; k < 3; k++) begin
                    r_mag[g][k] <= w_c[k][CRW-1] ? w_neg[k][MW-1:0] : w_c[k][MW-1:0];
                    r_hh[g][k]  <= (2*HW)'(r_mag[g][k][MW-1:HW]) *
                                   (2*HW)'(r_mag[g][k][MW-1:HW]);
                    r_hl[g][k]  <= (2*HW)'(r_mag[g][k][MW-1:HW]) *
                                   (2*HW)'(r_mag[g][k][HW-1:0]);
                    r_ll[g][k]  <= (2*HW)'(r_mag[g][k][HW-1:0]) *
                                   (2*HW)'(r_mag[g][k][HW-1:0]);
                    r_sq[g][k]  <= (SQW'(r_hh[g][k]) << MW) +
                                   (SQW'(r_hl[g][k]) << (HW + 1)) + SQW'(r_ll[g][k]);
                end
                r_sum[g] <= SW'(r_sq[g][0]) + SW'(r_sq[g][1]) + SW'(r_sq[g][2]);
            end
        end

        pitb_sqrt u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_v[5]),
            .i_rad   ({r_sum[g], {FRACS{1'b0}}}),
            .o_valid (w_sq_valid[g]),
            .o_root  (w_len[g])
        );
    end

    pitb_div u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid[0]),
        .i_num   (w_len[1]),
        .i_den   (w_len[0]),
        .o_valid (w_u_valid),
        .o_q     (w_u)
    );

    pitb_div u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid[0]),
        .i_num   (w_len[2]),
        .i_den   (w_len[0]),
        .o_valid (w_v_valid),
        .o_q     (w_v)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dg[0] <= (w_len[0] == '0);
            for (int s = 1; s < QW; s++) begin
                r_dg[s] <= r_dg[s-1];
            end
        end
    end

    logic signed [XW-1:0] w_w;
    logic signed [XW-1:0] w_thr;
    logic [WWW-1:0]       w_wc;
    logic                 w_in;

    assign w_w   = $signed(ONE_Q - {2'b00, w_u} - {2'b00, w_v});
    assign w_thr = $signed({{(XW-MWT){1'b0}}, r_min_weight});
    assign w_wc  = (w_w < W_FLOOR) ? W_OUT_MIN : w_w[WWW-1:0];
    assign w_in  = (w_u >= {{(QW-MWT){1'b0}}, r_min_weight}) &&
                   (w_v >= {{(QW-MWT){1'b0}}, r_min_weight}) && (w_w >= w_thr);

    logic           r_out_valid;
    logic [QW-1:0]  r_wu;
    logic [QW-1:0]  r_wv;
    logic [WWW-1:0] r_ww;
    logic           r_inside;
    logic           r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_u_valid;
        end
        if (w_en) begin
            r_degen  <= r_dg[QW-1];
            r_wu     <= r_dg[QW-1] ? '0 : w_u;
            r_wv     <= r_dg[QW-1] ? '0 : w_v;
            r_ww     <= r_dg[QW-1] ? '0 : w_wc;
            r_inside <= r_dg[QW-1] ? 1'b0 : w_in;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_weight_u   = r_wu;
    assign o_weight_v   = r_wv;
    assign o_weight_w   = r_ww;
    assign o_inside_res = r_inside;
    assign o_degenerate = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_weight_u == '0 && o_inside_res == 1'b0))
        else $error("degenerate word carries weights");

    a_inside_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_inside_res) |-> (o_weight_u >= {{(QW-MWT){1'b0}}, r_min_weight}))
        else $error("inside set below threshold");

    a_lanes_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_u_valid == w_v_valid)
        else $error("divider lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

FILE: design/pitb_sqrt.sv
module pitb_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [pitb_pkg::RW-1:0]   i_rad,
    output logic                      o_valid,
    output logic [pitb_pkg::LW-1:0]   o_root
);
    import pitb_pkg::*;

    logic [RW-1:0] r_x    [LW];
    logic [LW:0]   r_rem  [LW];
    logic [LW-1:0] r_root [LW];
    logic          r_v    [LW];

    for (genvar k = 0; k < LW; k++) begin : g_stage
        logic [RW-1:0] w_xp;
        logic [LW:0]   w_remp;
        logic [LW-1:0] w_rootp;
        logic          w_vp;
        logic [LW+2:0] w_t;
        logic [LW+2:0] w_trial;
        logic [LW+2:0] w_d;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_xp    = i_rad;
            assign w_remp  = '0;
            assign w_rootp = '0;
            assign w_vp    = i_valid;
        end else begin : g_next
            assign w_xp    = r_x[k-1];
            assign w_remp  = r_rem[k-1];
            assign w_rootp = r_root[k-1];
            assign w_vp    = r_v[k-1];
        end

        assign w_t     = {w_remp, w_xp[RW-1:RW-2]};
        assign w_trial = {1'b0, w_rootp, 2'b01};
        assign w_d     = w_t - w_trial;
        assign w_ge    = w_t >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vp;
            end
            if (i_en) begin
                r_x[k]    <= {w_xp[RW-3:0], 2'b00};
                r_rem[k]  <= w_ge ? w_d[LW:0] : w_t[LW:0];
                r_root[k] <= {w_rootp[LW-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[LW-1];
    assign o_root  = r_root[LW-1];

endmodule

FILE: design/pitb_div.sv
module pitb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [pitb_pkg::LW-1:0]   i_num,
    input  logic [pitb_pkg::LW-1:0]   i_den,
    output logic                      o_valid,
    output logic [pitb_pkg::QW-1:0]   o_q
);
    import pitb_pkg::*;

    logic [RMW-1:0] r_rem [QW];
    logic [LW-1:0]  r_den [QW];
    logic [QW-1:0]  r_q   [QW];
    logic           r_sat [QW];
    logic           r_v   [QW];

    logic w_sat_in;
    assign w_sat_in = {4'b0000, i_num} >= {i_den, 4'b0000};

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [RMW-1:0] w_remp;
        logic [LW-1:0]  w_denp;
        logic [QW-1:0]  w_qp;
        logic           w_satp;
        logic           w_vp;
        logic [RMW-1:0] w_dsh;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_remp = RMW'(i_num) << QF;
            assign w_denp = i_den;
            assign w_qp   = '0;
            assign w_satp = w_sat_in;
            assign w_vp   = i_valid;
        end else begin : g_next
            assign w_remp = r_rem[k-1];
            assign w_denp = r_den[k-1];
            assign w_qp   = r_q[k-1];
            assign w_satp = r_sat[k-1];
            assign w_vp   = r_v[k-1];
        end

        assign w_dsh = RMW'(w_denp) << SH;
        assign w_ge  = w_remp >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_vp;
            end
            if (i_en) begin
                r_rem[k] <= w_ge ? (w_remp - w_dsh) : w_remp;
                r_den[k] <= w_denp;
                r_q[k]   <= {w_qp[QW-2:0], w_ge};
                r_sat[k] <= w_satp;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_sat[QW-1] ? '1 : r_q[QW-1];

endmodule
